>>> rtl/core/gvps_pkg.sv
// Shared types, widths and constants of the Gaussian velocity profile sum.
// Holds the component record, divider and multiplier request and response structs and the
// exp(-w/2) node table. Depends on nothing.
package gvps_pkg;

  localparam int MAX_COMPONENTS  = 8;
  localparam int EXP_TABLE_DEPTH = 256;

  localparam int IDX_W  = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int CNT_W  = $clog2(MAX_COMPONENTS + 1);
  localparam int CC_W   = 4;
  localparam int SLOT_W = 3;
  localparam int FLUX_W = 48;
  localparam int TDATA_W = 168;

  // Radix-2 divider geometry
  localparam int DIV_DVD_W  = 94;
  localparam int DIV_DEN_W  = 64;
  localparam int DIV_Q_W    = 88;
  localparam int DIV_STEP_W = 7;
  localparam logic [DIV_STEP_W-1:0] DIV_STEPS_Q = 7'd94;
  localparam logic [DIV_STEP_W-1:0] DIV_STEPS_X = 7'd49;
  localparam logic [DIV_STEP_W-1:0] DIV_STEPS_G = 7'd88;

  // Serial multiplier geometry
  localparam int MUL_P_W  = 40;
  localparam int MUL_GI_W = 64;
  localparam int MUL_GF_W = 24;
  localparam int MUL_I_W  = 50;
  localparam int MUL_F_W  = 64;
  localparam logic [6:0] MUL_STEPS = 7'd64;

  // Exp table indexing
  localparam int W_W       = 23;
  localparam int POS_W     = W_W + $clog2(EXP_TABLE_DEPTH);
  localparam int EFRAC_W   = 22;
  localparam int EIDX_W    = POS_W - EFRAC_W;
  localparam int ROM_IDX_W = $clog2(EXP_TABLE_DEPTH + 1);

  localparam logic [30:0] C_KMS_Q12 = 31'd1227949908;
  localparam logic [FLUX_W-1:0] FLUX_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [FLUX_W-1:0] FLUX_MIN = 48'h8000_0000_0000;

  // Series argument: node spacing 32/depth in Q0.30
  localparam longint unsigned EXP_X0 = (64'd32 << 30) / EXP_TABLE_DEPTH;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } opcode_t;

  typedef struct packed {
    logic [31:0] sigma;
    logic [31:0] center;
    logic [31:0] amp;
    logic [31:0] rest;
  } comp_t;

  typedef struct packed {
    logic                  start;
    logic [DIV_DVD_W-1:0]  dividend;
    logic [DIV_DEN_W-1:0]  divisor;
    logic [DIV_STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DIV_Q_W-1:0] quotient;
  } div_resp_t;

  typedef struct packed {
    logic                start;
    logic [MUL_P_W-1:0]  p;
    logic [MUL_GI_W-1:0] gi;
    logic [MUL_GF_W-1:0] gf;
  } mul_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic               ovf;
    logic [MUL_I_W-1:0] prod_i;
    logic [MUL_F_W-1:0] prod_f;
  } mul_resp_t;

  typedef logic [30:0] exp_node_t;
  typedef exp_node_t exp_rom_t [EXP_TABLE_DEPTH+1];

  // Long division by a small series index, shift and subtract
  function automatic longint unsigned udiv_small(longint unsigned num,
                                                 longint unsigned den);
    longint unsigned q;
    longint unsigned rem;
    q   = 64'd0;
    rem = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      q   = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q   = q | 64'd1;
      end
    end
    return q;
  endfunction

  // Node k holds exp(-32k/depth) in Q0.30, stepped by a series-derived ratio
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t        rom;
    longint unsigned x0;
    longint unsigned term;
    longint unsigned step;
    longint          sum;
    x0   = EXP_X0;
    term = 64'd1 << 30;
    sum  = longint'(term);
    for (int n = 1; n <= 24; n++) begin
      term = udiv_small((term * x0) >> 30, 64'(n));
      if (n % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    step   = (sum < 0) ? 64'd0 : 64'(sum);
    rom[0] = 31'd1073741824;
    for (int k = 1; k <= EXP_TABLE_DEPTH; k++) begin
      rom[k] = 31'(((64'(rom[k-1]) * step) + (64'd1 << 29)) >> 30);
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

>>> rtl/core/gvps_comp_ram.sv
// Component table: one synchronous memory of rest, amplitude, center, sigma.
// Single write port, single registered read port. Uses gvps_pkg.
module gvps_comp_ram (
  input  logic                   clk,
  input  logic                   we,
  input  logic [gvps_pkg::IDX_W-1:0] waddr,
  input  gvps_pkg::comp_t        wdata,
  input  logic                   re,
  input  logic [gvps_pkg::IDX_W-1:0] raddr,
  output gvps_pkg::comp_t        rdata
);
  import gvps_pkg::*;

  comp_t mem [MAX_COMPONENTS];

  // Write one component record
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/gvps_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Takes a left-aligned dividend and a step count. Uses gvps_pkg.
module gvps_div (
  input  logic                clk,
  input  logic                rst,
  input  gvps_pkg::div_req_t  req,
  output gvps_pkg::div_resp_t resp
);
  import gvps_pkg::*;

  logic                  busy;
  logic                  done;
  logic [DIV_STEP_W-1:0] cnt;
  logic [DIV_DVD_W-1:0]  dvd;
  logic [DIV_DEN_W-1:0]  dvs;
  logic [DIV_DEN_W-1:0]  rem;
  logic [DIV_Q_W-1:0]    quo;
  logic [DIV_DEN_W:0]    trial;
  logic [DIV_DEN_W:0]    diff;
  logic                  ge;

  assign trial = {rem, dvd[DIV_DVD_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = trial >= {1'b0, dvs};

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift and subtract
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      dvd <= {dvd[DIV_DVD_W-2:0], 1'b0};
      rem <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      quo <= {quo[DIV_Q_W-2:0], ge};
    end
  end

  assign resp.busy     = busy;
  assign resp.done     = done;
  assign resp.quotient = quo;

endmodule

>>> rtl/core/gvps_smul.sv
// Bit-serial multiplier of p by the factor gi.gf, MSB first.
// Integer product sets a sticky overflow flag above 2^48. Uses gvps_pkg.
module gvps_smul (
  input  logic                clk,
  input  logic                rst,
  input  gvps_pkg::mul_req_t  req,
  output gvps_pkg::mul_resp_t resp
);
  import gvps_pkg::*;

  localparam logic [MUL_I_W-1:0] LIM = 50'd1 << 48;

  logic                busy;
  logic                done;
  logic [6:0]          cnt;
  logic [MUL_P_W-1:0]  p;
  logic [MUL_GI_W-1:0] gi_sh;
  logic [MUL_GF_W-1:0] gf_sh;
  logic [MUL_I_W-1:0]  ai;
  logic [MUL_F_W-1:0]  af;
  logic                ovf;
  logic [MUL_I_W-1:0]  ai_step;
  logic [MUL_F_W-1:0]  af_step;

  assign ai_step = {ai[MUL_I_W-2:0], 1'b0} + (gi_sh[MUL_GI_W-1] ? MUL_I_W'(p) : '0);
  assign af_step = {af[MUL_F_W-2:0], 1'b0} + (gf_sh[MUL_GF_W-1] ? MUL_F_W'(p) : '0);

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= MUL_STEPS;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Accumulate integer and fraction products
  always_ff @(posedge clk) begin
    if (req.start) begin
      p     <= req.p;
      gi_sh <= req.gi;
      gf_sh <= req.gf;
      ai    <= '0;
      af    <= '0;
      ovf   <= 1'b0;
    end else if (busy) begin
      gi_sh <= {gi_sh[MUL_GI_W-2:0], 1'b0};
      if (!ovf) begin
        ai <= ai_step;
        if (ai_step > LIM) begin
          ovf <= 1'b1;
        end
      end
      if (cnt <= 7'(MUL_GF_W)) begin
        af    <= af_step;
        gf_sh <= {gf_sh[MUL_GF_W-2:0], 1'b0};
      end
    end
  end

  assign resp.busy   = busy;
  assign resp.done   = done;
  assign resp.ovf    = ovf;
  assign resp.prod_i = ai;
  assign resp.prod_f = af;

endmodule

>>> rtl/core/gaussian_velocity_profile_sum.sv
// Gaussian velocity profile sum: a load transaction writes one component into
// the table. An evaluate transaction walks the first component_count slots
// (at most MAX_COMPONENTS) and delivers one flux. Each component runs through a
// shared radix-2 divider up to three times (94, 49 and 88 steps) and a 64-step
// serial multiplier; a component beyond 8 sigma stops after the first division.
// A zero divisor or a saturation ends the walk early; zero components give flux
// 0. A finished flux waits in the output register while the next transaction is
// taken.
// Depends on gvps_pkg, gvps_comp_ram, gvps_div and gvps_smul.
module gaussian_velocity_profile_sum (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [gvps_pkg::CC_W-1:0]    cfg_wdata,     // component_count
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // slot[2:0], sample_wavelength[34:3], line_rest[66:35],
  // amplitude[98:67], center_velocity[130:99], width_sigma[162:131], zero pad
  input  logic [gvps_pkg::TDATA_W-1:0] s_axis_tdata,
  input  logic                         s_axis_tuser,  // opcode
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [gvps_pkg::FLUX_W-1:0]  m_axis_tdata,  // flux
  output logic                         m_axis_tuser   // saturated
);
  import gvps_pkg::*;

  typedef enum logic [24:0] {
    S_IDLE  = 25'h0000001,
    S_READ  = 25'h0000002,
    S_SQ    = 25'h0000004,
    S_CHK   = 25'h0000008,
    S_QST   = 25'h0000010,
    S_QWAIT = 25'h0000020,
    S_VEL   = 25'h0000040,
    S_DIFF  = 25'h0000080,
    S_DIST  = 25'h0000100,
    S_XST   = 25'h0000200,
    S_XWAIT = 25'h0000400,
    S_SQW   = 25'h0000800,
    S_EIDX  = 25'h0001000,
    S_EHI   = 25'h0002000,
    S_ELO   = 25'h0004000,
    S_EMUL  = 25'h0008000,
    S_EXP   = 25'h0010000,
    S_PMUL  = 25'h0020000,
    S_GWAIT = 25'h0040000,
    S_MST   = 25'h0080000,
    S_MWAIT = 25'h0100000,
    S_MAG   = 25'h0200000,
    S_ACC   = 25'h0400000,
    S_NEXT  = 25'h0800000,
    S_DONE  = 25'h1000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [CC_W-1:0]   component_count;
  logic [CNT_W-1:0]  k;
  logic [CNT_W-1:0]  cnt;
  logic [31:0]       wl;
  comp_t             cp;
  comp_t             ram_rdata;
  logic [63:0]       ah;
  logic [63:0]       bh;
  logic              zero_in;
  logic [63:0]       num;
  logic [63:0]       diffmag;
  logic              vneg;
  logic [31:0]       vmag;
  logic signed [33:0] t;
  logic [32:0]       d;
  logic [W_W-1:0]    w;
  logic [EIDX_W-1:0] eidx;
  logic [EFRAC_W-1:0] efrac;
  logic              eclamp;
  logic [ROM_IDX_W-1:0] lo_idx;
  logic [30:0]       hi;
  logic [30:0]       lo;
  logic [52:0]       iprod;
  logic [30:0]       e;
  logic [MUL_P_W-1:0] p;
  logic [49:0]       mag;
  logic [FLUX_W-1:0] acc;
  logic              sat;

  // Input field views
  logic [SLOT_W-1:0] in_slot;
  opcode_t           in_op;
  comp_t             in_comp;
  logic [31:0]       in_wl;
  logic              in_accept;

  assign in_slot        = s_axis_tdata[2:0];
  assign in_wl          = s_axis_tdata[34:3];
  assign in_comp.rest   = s_axis_tdata[66:35];
  assign in_comp.amp    = s_axis_tdata[98:67];
  assign in_comp.center = s_axis_tdata[130:99];
  assign in_comp.sigma  = s_axis_tdata[162:131];
  assign in_op          = opcode_t'(s_axis_tuser);
  assign s_axis_tready  = (state == S_IDLE);
  assign in_accept      = s_axis_tvalid && s_axis_tready;

  // Component table
  logic ram_we;
  assign ram_we = in_accept && (in_op == OP_LOAD) &&
                  (32'(in_slot) < 32'(MAX_COMPONENTS));

  gvps_comp_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_W'(in_slot)),
    .wdata (in_comp),
    .re    (state == S_READ),
    .raddr (k[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // Shared divider and serial multiplier
  div_req_t  div_req;
  div_resp_t div_resp;
  mul_req_t  mul_req;
  mul_resp_t mul_resp;

  gvps_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .resp (div_resp)
  );

  gvps_smul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mul_req),
    .resp (mul_resp)
  );

  // Combinational datapath helpers
  logic              neg;
  logic              far;
  logic              out_free;
  logic [CNT_W-1:0]  count_eff;
  logic [63:0]       a_full;
  logic [63:0]       b_full;
  logic              halve;
  logic [61:0]       vprod;
  logic [39:0]       xx;
  logic [POS_W-1:0]  pos;
  logic [31:0]       amag;
  logic [62:0]       pprod;
  logic [63:0]       pround;
  logic [64:0]       fround;
  logic signed [49:0] acc_ext;
  logic signed [49:0] s50;
  logic              zero_div;
  logic [33:0]       t_neg;

  assign neg      = cp.amp[31];
  assign far      = {2'b00, d} > {cp.sigma, 3'b000};
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign count_eff = (32'(component_count) > 32'(MAX_COMPONENTS)) ?
                     CNT_W'(MAX_COMPONENTS) : CNT_W'(component_count);
  assign a_full   = wl * wl;
  assign b_full   = ram_rdata.rest * ram_rdata.rest;
  assign halve    = a_full[63] | b_full[63];
  assign vprod    = div_resp.quotient[30:0] * C_KMS_Q12;
  assign xx       = div_resp.quotient[19:0] * div_resp.quotient[19:0];
  assign pos      = POS_W'(w) * POS_W'(EXP_TABLE_DEPTH);
  assign amag     = neg ? (~cp.amp + 32'd1) : cp.amp;
  assign pprod    = amag * e;
  assign pround   = 64'(pprod) + (64'd1 << 21);
  assign fround   = 65'(mul_resp.prod_f) + (65'd1 << 23);
  assign acc_ext  = {{2{acc[FLUX_W-1]}}, acc};
  assign s50      = neg ? (acc_ext - $signed(mag)) : (acc_ext + $signed(mag));
  assign zero_div = zero_in || (ah == 64'd0) || (cp.sigma == 32'd0);
  assign t_neg    = ~t + 34'd1;

  // Divider requests
  always_comb begin
    div_req = '0;
    case (state)
      S_QST: begin
        div_req.start    = 1'b1;
        div_req.dividend = {diffmag, 30'b0};
        div_req.divisor  = num;
        div_req.steps    = DIV_STEPS_Q;
      end
      S_XST: begin
        div_req.start    = !far;
        div_req.dividend = {d, 16'b0, 45'b0};
        div_req.divisor  = {32'b0, cp.sigma};
        div_req.steps    = DIV_STEPS_X;
      end
      S_PMUL: begin
        div_req.start    = 1'b1;
        div_req.dividend = {num, 30'b0};
        div_req.divisor  = {ah[62:0], 1'b0};
        div_req.steps    = DIV_STEPS_G;
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  // Serial multiplier request
  always_comb begin
    mul_req.start = (state == S_MST);
    mul_req.p     = p;
    mul_req.gi    = div_resp.quotient[DIV_Q_W-1:MUL_GF_W];
    mul_req.gf    = div_resp.quotient[MUL_GF_W-1:0];
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_accept && (in_op == OP_EVAL)) begin
          state_next = (count_eff == '0) ? S_DONE : S_READ;
        end
      end
      S_READ:  state_next = S_SQ;
      S_SQ:    state_next = S_CHK;
      S_CHK:   state_next = zero_div ? S_DONE : S_QST;
      S_QST:   state_next = S_QWAIT;
      S_QWAIT: state_next = div_resp.done ? S_VEL : S_QWAIT;
      S_VEL:   state_next = S_DIFF;
      S_DIFF:  state_next = S_DIST;
      S_DIST:  state_next = S_XST;
      S_XST:   state_next = far ? S_NEXT : S_XWAIT;
      S_XWAIT: state_next = div_resp.done ? S_SQW : S_XWAIT;
      S_SQW:   state_next = S_EIDX;
      S_EIDX:  state_next = S_EHI;
      S_EHI:   state_next = S_ELO;
      S_ELO:   state_next = S_EMUL;
      S_EMUL:  state_next = S_EXP;
      S_EXP:   state_next = S_PMUL;
      S_PMUL:  state_next = S_GWAIT;
      S_GWAIT: state_next = div_resp.done ? S_MST : S_GWAIT;
      S_MST:   state_next = S_MWAIT;
      S_MWAIT: state_next = mul_resp.done ? S_MAG : S_MWAIT;
      S_MAG:   state_next = mul_resp.ovf ? S_DONE : S_ACC;
      S_ACC: begin
        if ((mag > (50'd1 << 47)) || (s50 > $signed({2'b00, FLUX_MAX})) ||
            (s50 < $signed({2'b11, FLUX_MIN}))) begin
          state_next = S_DONE;
        end else begin
          state_next = S_NEXT;
        end
      end
      S_NEXT:  state_next = ((k + 1'b1) == cnt) ? S_DONE : S_READ;
      S_DONE:  state_next = out_free ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      component_count <= '0;
      m_axis_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        component_count <= cfg_wdata;
      end
      if ((state == S_DONE) && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_accept && (in_op == OP_EVAL)) begin
          wl  <= in_wl;
          acc <= '0;
          sat <= 1'b0;
          k   <= '0;
          cnt <= count_eff;
        end
      end
      S_SQ: begin
        cp      <= ram_rdata;
        zero_in <= (wl == 32'd0) || (ram_rdata.rest == 32'd0);
        ah      <= halve ? (a_full >> 1) : a_full;
        bh      <= halve ? (b_full >> 1) : b_full;
      end
      S_CHK: begin
        if (zero_div) begin
          acc <= neg ? FLUX_MIN : FLUX_MAX;
          sat <= 1'b1;
        end
        num     <= ah + bh;
        diffmag <= (ah >= bh) ? (ah - bh) : (bh - ah);
        vneg    <= ah < bh;
      end
      S_VEL: begin
        vmag <= 32'((62'(vprod) + (62'd1 << 29)) >> 30);
      end
      S_DIFF: begin
        t <= vneg ? ($signed({2'b00, vmag}) + $signed({{2{cp.center[31]}}, cp.center}))
                  : ($signed({2'b00, vmag}) - $signed({{2{cp.center[31]}}, cp.center}));
      end
      S_DIST: begin
        d <= t[33] ? t_neg[32:0] : t[32:0];
      end
      S_SQW: begin
        w <= xx[38:16];
      end
      S_EIDX: begin
        eidx  <= pos[POS_W-1:EFRAC_W];
        efrac <= pos[EFRAC_W-1:0];
      end
      S_EHI: begin
        // Clamp past the last node, else read the bracketing pair
        if (eidx >= EIDX_W'(EXP_TABLE_DEPTH)) begin
          eclamp <= 1'b1;
          hi     <= EXP_ROM[ROM_IDX_W'(EXP_TABLE_DEPTH)];
          lo_idx <= ROM_IDX_W'(EXP_TABLE_DEPTH);
        end else begin
          eclamp <= 1'b0;
          hi     <= EXP_ROM[ROM_IDX_W'(eidx)];
          lo_idx <= ROM_IDX_W'(eidx) + 1'b1;
        end
      end
      S_ELO: begin
        lo <= EXP_ROM[lo_idx];
      end
      S_EMUL: begin
        iprod <= (hi - lo) * efrac;
      end
      S_EXP: begin
        e <= (eclamp || (lo > hi)) ? hi : (hi - iprod[52:22]);
      end
      S_PMUL: begin
        p <= pround[61:22];
      end
      S_MAG: begin
        if (mul_resp.ovf) begin
          acc <= neg ? FLUX_MIN : FLUX_MAX;
          sat <= 1'b1;
        end
        mag <= mul_resp.prod_i + 50'(fround[64:24]);
      end
      S_ACC: begin
        if (mag > (50'd1 << 47)) begin
          acc <= neg ? FLUX_MIN : FLUX_MAX;
          sat <= 1'b1;
        end else if (s50 > $signed({2'b00, FLUX_MAX})) begin
          acc <= FLUX_MAX;
          sat <= 1'b1;
        end else if (s50 < $signed({2'b11, FLUX_MIN})) begin
          acc <= FLUX_MIN;
          sat <= 1'b1;
        end else begin
          acc <= s50[FLUX_W-1:0];
        end
      end
      S_NEXT: begin
        k <= k + 1'b1;
      end
      S_DONE: begin
        if (out_free) begin
          m_axis_tdata <= acc;
          m_axis_tuser <= sat;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // Divider is never restarted mid-division
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_resp.busy)
    else $error("divider started while busy");

  // Component reads stay inside the evaluated range
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (k < cnt))
    else $error("component index beyond count");

  // A saturated result always carries an extreme flux
  a_sat_flux: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |->
      ((m_axis_tdata == FLUX_MAX) || (m_axis_tdata == FLUX_MIN)))
    else $error("saturated flag without extreme flux");
`endif

endmodule

>>> dv/testbench.sv
// Self-checking testbench for gaussian_velocity_profile_sum: loads components,
// evaluates wavelengths and checks every flux against an in-bench predictor.
// Depends on gvps_pkg and the RTL top level.
module testbench;
  import gvps_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int WATCHDOG_MAX = 20000;
  localparam int SETTLE       = 50;
  localparam int LONG_HOLD    = 4000;
  localparam longint FLUX_HI  = 64'sd140737488355327;
  localparam longint FLUX_LO  = -64'sd140737488355328;

  typedef struct {
    opcode_t     op;
    logic [2:0]  slot;
    logic [31:0] wl;
    logic [31:0] rest;
    logic [31:0] amp;
    logic [31:0] ctr;
    logic [31:0] sig;
  } line_item_t;

  typedef struct {
    logic [47:0] flux;
    logic        sat;
  } flux_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CC_W-1:0] cfg_wdata = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [FLUX_W-1:0] m_axis_tdata;
  logic m_axis_tuser;

  gaussian_velocity_profile_sum u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always #CLK_HALF clk = ~clk;

  // Predictor state: component table, active count and exp nodes
  logic [31:0] rest_mem [MAX_COMPONENTS];
  logic [31:0] amp_mem [MAX_COMPONENTS];
  logic [31:0] ctr_mem [MAX_COMPONENTS];
  logic [31:0] sig_mem [MAX_COMPONENTS];
  logic [3:0]  active_count = '0;
  longint unsigned exp_node [EXP_TABLE_DEPTH+1];

  line_item_t line_items [$];
  flux_res_t  flux_expected [$];
  line_item_t cur;
  logic tx_pause = 1'b0;
  int hold_kick = 0;
  int n_loads = 0, n_evals = 0, n_checked = 0, n_sat = 0, n_mismatch = 0;
  int quiet_cycles = 0;

  // floor(num * 2^bits / den), saturating at 2^bits when num >= den
  function automatic longint unsigned frac_bits(longint unsigned num,
                                               longint unsigned den, int bits);
    longint unsigned q, rem;
    if (num >= den) return 64'd1 << bits;
    q = 0;
    rem = num;
    for (int i = 0; i < bits; i++) begin
      q = q << 1;
      if (rem >= den - rem) begin
        rem = rem - (den - rem);
        q = q | 64'd1;
      end else begin
        rem = rem + rem;
      end
    end
    return q;
  endfunction

  // Node ratio from a truncated series, then repeated rounded products
  task automatic fill_exp_nodes();
    longint unsigned x0, term, step;
    longint acc;
    x0 = (64'd32 << 30) / EXP_TABLE_DEPTH;
    term = 64'd1 << 30;
    acc = longint'(term);
    for (int n = 1; n <= 24; n++) begin
      term = ((term * x0) >> 30) / longint'(n);
      if (n % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    step = (acc < 0) ? 64'd0 : longint'(acc);
    exp_node[0] = 64'd1 << 30;
    for (int k = 1; k <= EXP_TABLE_DEPTH; k++) begin
      exp_node[k] = (exp_node[k-1] * step + (64'd1 << 29)) >> 30;
    end
  endtask

  // exp(-w/2) for w in Q7.16, linear between nodes, Q0.30
  function automatic longint unsigned half_exp(longint unsigned w);
    longint unsigned pos, idx, fr, hi, lo;
    pos = w * EXP_TABLE_DEPTH;
    idx = pos >> 22;
    fr = pos & ((64'd1 << 22) - 1);
    if (idx >= EXP_TABLE_DEPTH) return exp_node[EXP_TABLE_DEPTH];
    hi = exp_node[idx];
    lo = exp_node[idx+1];
    if (lo > hi) return hi;
    return hi - (((hi - lo) * fr) >> 22);
  endfunction

  // Sum the active Gaussian terms for one observed wavelength
  function automatic flux_res_t profile_flux(logic [31:0] wl_in);
    flux_res_t r;
    longint unsigned wl, rest, sigma, a, b, q, vmag, d, x, w, e, p, num, den;
    longint unsigned gi, gf, mag;
    longint amp, centre, v, diff, acc;
    logic neg, sat;
    int cnt;
    wl = wl_in;
    acc = 0;
    sat = 1'b0;
    cnt = (active_count > MAX_COMPONENTS) ? MAX_COMPONENTS : active_count;
    for (int k = 0; k < cnt && !sat; k++) begin
      rest = rest_mem[k];
      amp = longint'(signed'(amp_mem[k]));
      centre = longint'(signed'(ctr_mem[k]));
      sigma = sig_mem[k];
      neg = amp < 0;
      if (wl == 0 || rest == 0) begin
        acc = neg ? FLUX_LO : FLUX_HI;
        sat = 1'b1;
        break;
      end
      a = wl * wl;
      b = rest * rest;
      if (a[63] | b[63]) begin
        a = a >> 1;
        b = b >> 1;
      end
      if (a == 0 || sigma == 0) begin
        acc = neg ? FLUX_LO : FLUX_HI;
        sat = 1'b1;
        break;
      end
      num = a + b;
      q = frac_bits((a >= b) ? a - b : b - a, num, 30);
      vmag = (q * 64'd1227949908 + (64'd1 << 29)) >> 30;
      v = (a >= b) ? longint'(vmag) : -longint'(vmag);
      diff = v - centre;
      d = (diff < 0) ? longint'(-diff) : longint'(diff);
      // skip components beyond eight sigma
      if (d > 8 * sigma) continue;
      x = (d << 16) / sigma;
      w = (x * x) >> 16;
      e = half_exp(w);
      p = (longint'(neg ? -amp : amp) * e + (64'd1 << 21)) >> 22;
      den = a << 1;
      gi = num / den;
      gf = frac_bits(num % den, den, 24);
      if (gi != 0 && p > (64'd1 << 48) / gi) begin
        acc = neg ? FLUX_LO : FLUX_HI;
        sat = 1'b1;
        break;
      end
      mag = p * gi + ((p * gf + (64'd1 << 23)) >> 24);
      if (mag > (64'd1 << 47)) begin
        acc = neg ? FLUX_LO : FLUX_HI;
        sat = 1'b1;
        break;
      end
      acc = acc + (neg ? -longint'(mag) : longint'(mag));
      if (acc > FLUX_HI) begin
        acc = FLUX_HI;
        sat = 1'b1;
      end else if (acc < FLUX_LO) begin
        acc = FLUX_LO;
        sat = 1'b1;
      end
    end
    r.flux = acc[47:0];
    r.sat = sat;
    return r;
  endfunction

  // Sender: bursts of offers separated by random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (cur.op == OP_LOAD) begin
          rest_mem[cur.slot] = cur.rest;
          amp_mem[cur.slot] = cur.amp;
          ctr_mem[cur.slot] = cur.ctr;
          sig_mem[cur.slot] = cur.sig;
          n_loads++;
        end else begin
          flux_expected.push_back(profile_flux(cur.wl));
          n_evals++;
        end
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (line_items.size() > 0 && !tx_pause) begin
          cur = line_items.pop_front();
          s_axis_tdata <= {5'b0, cur.sig, cur.ctr, cur.amp, cur.rest, cur.wl, cur.slot};
          s_axis_tuser <= cur.op;
          s_axis_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern that changes mode, plus requested long holds
  int hold_left = 0;
  int hold_seen = 0;
  int rx_mode = 0;
  int rx_phase = 0;
  always @(posedge clk) begin
    rx_phase++;
    if (rx_phase % 97 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_kick != hold_seen) begin
      hold_seen = hold_kick;
      hold_left = LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= (rx_phase % 4 == 0);
        default: m_axis_tready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // Monitor: compare each flux transaction with the oldest expectation
  always @(posedge clk) begin
    flux_res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (flux_expected.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected result: flux=%h sat=%b", m_axis_tdata, m_axis_tuser);
      end else begin
        want = flux_expected.pop_front();
        n_checked++;
        if (want.sat) n_sat++;
        if (want.flux !== m_axis_tdata || want.sat !== m_axis_tuser) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch #%0d: flux exp=%h got=%h sat exp=%b got=%b",
                     n_checked, want.flux, m_axis_tdata, want.sat, m_axis_tuser);
        end
      end
    end
  end

  // Watchdog: end the run after too long without any transaction
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_MAX);
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic line_item_t load_item(logic [2:0] slot, logic [31:0] rest,
                                          logic [31:0] amp, logic [31:0] ctr,
                                          logic [31:0] sig);
    line_item_t it;
    it.op = OP_LOAD;
    it.slot = slot;
    it.wl = $urandom;
    it.rest = rest;
    it.amp = amp;
    it.ctr = ctr;
    it.sig = sig;
    return it;
  endfunction

  function automatic line_item_t eval_item(logic [31:0] wl);
    line_item_t it;
    it.op = OP_EVAL;
    it.slot = 3'($urandom);
    it.wl = wl;
    it.rest = $urandom;
    it.amp = $urandom;
    it.ctr = $urandom;
    it.sig = $urandom;
    return it;
  endfunction

  // Plausible emission line: optical rest wavelength, modest sigma and shift
  function automatic line_item_t plausible_load();
    logic [31:0] amp;
    amp = $urandom_range(0, 32'h0040_0000);
    if ($urandom_range(0, 1)) amp = -amp;
    return load_item(3'($urandom),
                     ($urandom_range(4000, 7000) << 10) | $urandom_range(0, 1023),
                     amp, $urandom_range(0, 1) ? $urandom_range(0, 2000 << 12)
                                               : -$urandom_range(0, 2000 << 12),
                     $urandom_range(20 << 12, 400 << 12));
  endfunction

  function automatic line_item_t plausible_eval();
    logic [31:0] base;
    base = rest_mem[$urandom_range(0, MAX_COMPONENTS - 1)];
    return eval_item(base + $urandom_range(0, 80 << 10) - (40 << 10));
  endfunction

  task automatic write_count(logic [3:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    active_count = val;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (line_items.size() != 0 || s_axis_tvalid || flux_expected.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Stimulus sequencing: directed part, then random phases per count setting
  initial begin
    logic [3:0] counts [10] = '{4'd1, 4'd2, 4'd0, 4'd8, 4'd15, 4'd3, 4'd1, 4'd2, 4'd4, 4'd1};
    int roll;
    fill_exp_nodes();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // fill every slot before any evaluate can reach it
    line_items.push_back(load_item(3'd0, 32'd6563 << 10, 32'h0001_0000, 32'd0, 32'd100 << 12));
    line_items.push_back(load_item(3'd1, 32'd6563 << 10, 32'h8000_0000,
                                   32'h7FFF_FFFF, 32'hFFFF_FFFF));
    line_items.push_back(load_item(3'd2, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                   32'h8000_0000, 32'hFFFF_FFFF));
    line_items.push_back(load_item(3'd3, 32'd1, 32'd0, 32'd0, 32'd1));
    line_items.push_back(load_item(3'd4, 32'd4861 << 10, 32'hFFFF_0000, 32'd300 << 12,
                                   32'd50 << 12));
    line_items.push_back(load_item(3'd5, 32'd6563 << 10, 32'h7FFF_FFFF, 32'd0,
                                   32'hFFFF_FFFF));
    line_items.push_back(load_item(3'd6, 32'd0, 32'h0002_0000, 32'd0, 32'd100 << 12));
    line_items.push_back(load_item(3'd7, 32'd6563 << 10, 32'hFFFE_0000, 32'd0, 32'd0));
    drain();
    write_count(4'd2);
    // zero sample, exact rest, full scale and tiny wavelength (term overflow)
    line_items.push_back(eval_item(32'd0));
    line_items.push_back(eval_item(32'd6563 << 10));
    line_items.push_back(eval_item(32'hFFFF_FFFF));
    line_items.push_back(eval_item(32'd1));
    line_items.push_back(eval_item(32'd6600 << 10));
    drain();
    // zero components, then all slots incl. zero rest and zero sigma
    write_count(4'd0);
    line_items.push_back(eval_item(32'd6563 << 10));
    drain();
    write_count(4'd15);
    line_items.push_back(eval_item(32'd6563 << 10));
    line_items.push_back(eval_item(32'd4861 << 10));
    drain();
    write_count(4'd6);
    line_items.push_back(eval_item(32'hFFFF_FFFF));
    line_items.push_back(eval_item(32'd6563 << 10));
    line_items.push_back(eval_item(32'd3));
    drain();

    // restore a well-formed table before the random part
    for (int s = 0; s < MAX_COMPONENTS; s++) begin
      line_item_t it;
      it = plausible_load();
      it.slot = 3'(s);
      line_items.push_back(it);
    end
    drain();

    foreach (counts[ph]) begin
      write_count(counts[ph]);
      for (int i = 0; i < 96; i++) begin
        @(negedge clk);
        roll = $urandom_range(0, 99);
        if (roll < 40) line_items.push_back(plausible_load());
        else if (roll < 45)
          line_items.push_back(load_item(3'($urandom), $urandom, $urandom, $urandom,
                                         $urandom));
        else if (roll < 90) line_items.push_back(plausible_eval());
        else line_items.push_back(eval_item($urandom));
        if (ph == 3 && i == 10) hold_kick++;
        if (ph == 5 && i == 40) begin
          tx_pause = 1'b1;
          while (s_axis_tvalid || flux_expected.size() != 0) @(negedge clk);
          tx_pause = 1'b0;
        end
      end
      drain();
    end

    $display("summary: %0d loads, %0d evaluates checked (%0d saturated)", n_loads,
             n_checked, n_sat);
    $display("summary: %0d mismatches over count settings 0..15", n_mismatch);
    if (n_mismatch == 0 && flux_expected.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
